/* rtl/core/perspective_viewport_projection_defines.svh */
// Assertion macros used by the checker file of the projection block.
// Depends on nothing; each macro expects i_clk in scope, and PVP_ASSERT also expects i_rst_n.
`ifndef PERSPECTIVE_VIEWPORT_PROJECTION_DEFINES_SVH
`define PERSPECTIVE_VIEWPORT_PROJECTION_DEFINES_SVH

// Checked at every edge outside reset.
`define PVP_ASSERT(name, expr) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) expr) \
        else $error("pvp check failed");

// Checked at every edge, reset included.
`define PVP_ASSERT_ALWAYS(name, expr) \
    name: assert property (@(posedge i_clk) expr) \
        else $error("pvp check failed");

`endif

/* rtl/core/pvp_pkg.sv */
// Package of the perspective and viewport projection block.
// Holds payload types, register indexes and fixed constants; depends on nothing.
package pvp_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DIV_QBITS = 41;
    localparam int DIV_STAGES = DIV_QBITS + 1;
    localparam int CFG_IDX_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VIEW_DIST_H = 8'd0,
        CFG_VIEW_DIST_V = 8'd1,
        CFG_VIEWPORT_WIDTH = 8'd2,
        CFG_VIEWPORT_HEIGHT = 8'd3
    } t_cfg_idx;

    localparam logic [31:0] DIST_RESET = 32'h0001_0000;
    localparam logic [12:0] WIDTH_RESET = 13'd640;
    localparam logic [12:0] HEIGHT_RESET = 13'd480;
    localparam logic [DIV_QBITS-1:0] PX_LIMIT = DIV_QBITS'(1) << (DIV_QBITS - 1);

    typedef struct packed {
        logic signed [31:0] cam_x;
        logic signed [31:0] cam_y;
        logic signed [31:0] cam_z;
    } t_vertex;

    typedef struct packed {
        logic signed [31:0] screen_x;
        logic signed [31:0] screen_y;
        logic signed [31:0] screen_z;
        logic behind_camera;
    } t_screen;

    typedef struct packed {
        logic valid;
        logic behind;
        logic neg_x;
        logic neg_y;
        logic signed [31:0] z;
    } t_meta;

endpackage

/* rtl/core/pvp_div_pipe.sv */
// Pipelined restoring divider: 63-bit magnitude by a positive 31-bit divisor.
// One quotient bit per stage after an overflow check; uses pvp_pkg.
module pvp_div_pipe (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [62:0]                    i_num,
    input  logic [30:0]                    i_den,
    output logic [pvp_pkg::DIV_QBITS-1:0]  o_quo,
    output logic                           o_ovf
);
    localparam int QB = pvp_pkg::DIV_QBITS;
    localparam int NS = pvp_pkg::DIV_STAGES;

    logic [30:0]   r_rem [0:NS-1];
    logic [QB-1:0] r_low [0:NS-1];
    logic [QB-1:0] r_quo [0:NS-1];
    logic          r_ovf [0:NS-1];
    logic [30:0]   r_den [0:NS-1];

    logic [30:0]   n_rem [1:NS-1];
    logic [QB-1:0] n_low [1:NS-1];
    logic [QB-1:0] n_quo [1:NS-1];

    always_comb begin
        logic [31:0] t;
        for (int k = 1; k < NS; k++) begin
            t = {r_rem[k-1], r_low[k-1][QB-1]};
            n_low[k] = {r_low[k-1][QB-2:0], 1'b0};
            if (t >= {1'b0, r_den[k-1]}) begin
                n_rem[k] = 31'(t - {1'b0, r_den[k-1]});
                n_quo[k] = {r_quo[k-1][QB-2:0], 1'b1};
            end else begin
                n_rem[k] = t[30:0];
                n_quo[k] = {r_quo[k-1][QB-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= 31'(i_num[62:QB]);
            r_low[0] <= i_num[QB-1:0];
            r_quo[0] <= '0;
            r_ovf[0] <= ({9'd0, i_num[62:QB]} >= i_den);
            r_den[0] <= i_den;
            for (int k = 1; k < NS; k++) begin
                r_rem[k] <= n_rem[k];
                r_low[k] <= n_low[k];
                r_quo[k] <= n_quo[k];
                r_ovf[k] <= r_ovf[k-1];
                r_den[k] <= r_den[k-1];
            end
        end
    end

    assign o_quo = r_quo[NS-1];
    assign o_ovf = r_ovf[NS-1];
endmodule

/* rtl/core/perspective_viewport_projection.sv */
// Top level of the perspective divide and viewport transform block.
// Uses pvp_pkg and two pvp_div_pipe instances, one for x and one for y.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------
//  vertex   | i_valid / o_stall  | i_vertex (cam_x, cam_y, cam_z)
//  screen   | o_valid / i_stall  | o_result (screen_x/y/z, flag)
//  config   | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// One vertex is taken per cycle while no result is stalled; it passes the input, product,
// divider, clamp, scale and output registers; the dividers resolve one quotient bit per stage.
// The whole pipeline advances together and freezes only while a waiting result is stalled.
// Reset clears the valid bits and loads the register defaults.
module perspective_viewport_projection (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  pvp_pkg::t_vertex                    i_vertex,
    output logic                                o_valid,
    input  logic                                i_stall,
    output pvp_pkg::t_screen                    o_result,
    input  logic                                i_cfg_we,
    input  logic [pvp_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [31:0]                         i_cfg_data
);
    localparam int QB = pvp_pkg::DIV_QBITS;
    localparam int NS = pvp_pkg::DIV_STAGES;
    localparam int FB = pvp_pkg::FRAC_BITS;

    logic [31:0] r_dist_h, r_dist_v;
    logic [12:0] r_width, r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist_h <= pvp_pkg::DIST_RESET;
            r_dist_v <= pvp_pkg::DIST_RESET;
            r_width  <= pvp_pkg::WIDTH_RESET;
            r_height <= pvp_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pvp_pkg::CFG_VIEW_DIST_H:     r_dist_h <= i_cfg_data;
                pvp_pkg::CFG_VIEW_DIST_V:     r_dist_v <= i_cfg_data;
                pvp_pkg::CFG_VIEWPORT_WIDTH:  r_width  <= i_cfg_data[12:0];
                pvp_pkg::CFG_VIEWPORT_HEIGHT: r_height <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    // Input stage.
    logic             r_v0;
    pvp_pkg::t_vertex r_in;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v0 <= 1'b0;
        else if (en) r_v0 <= i_valid;
        if (en) r_in <= i_vertex;
    end

    // Magnitude products.
    logic [31:0]    ax, ay;
    logic           r_v1;
    pvp_pkg::t_meta r_m1;
    logic [63:0]    r_num_x, r_num_y;
    assign ax = r_in.cam_x[31] ? 32'(-r_in.cam_x) : r_in.cam_x;
    assign ay = r_in.cam_y[31] ? 32'(-r_in.cam_y) : r_in.cam_y;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else if (en) r_v1 <= r_v0;
        if (en) begin
            r_m1.valid  <= r_v0;
            r_m1.behind <= (r_in.cam_z <= 0);
            r_m1.neg_x  <= r_in.cam_x[31];
            r_m1.neg_y  <= r_in.cam_y[31];
            r_m1.z      <= r_in.cam_z;
            r_num_x     <= r_dist_h * ax;
            r_num_y     <= r_dist_v * ay;
        end
    end

    logic [QB-1:0] qx, qy;
    logic          ovf_x, ovf_y;
    logic [30:0]   den;
    assign den = (r_m1.z <= 0) ? 31'd1 : r_m1.z[30:0];

    pvp_div_pipe u_div_x (
        .i_clk(i_clk), .i_en(en), .i_num(r_num_x[62:0]), .i_den(den),
        .o_quo(qx), .o_ovf(ovf_x)
    );
    pvp_div_pipe u_div_y (
        .i_clk(i_clk), .i_en(en), .i_num(r_num_y[62:0]), .i_den(den),
        .o_quo(qy), .o_ovf(ovf_y)
    );

    logic           r_vd [0:NS-1];
    pvp_pkg::t_meta r_md [0:NS-1];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) r_vd[k] <= 1'b0;
        end else if (en) begin
            r_vd[0] <= r_v1;
            for (int k = 1; k < NS; k++) r_vd[k] <= r_vd[k-1];
        end
        if (en) begin
            r_md[0] <= r_m1;
            for (int k = 1; k < NS; k++) r_md[k] <= r_md[k-1];
        end
    end

    // Clamp and sign.
    logic [QB-1:0]       mx, my;
    logic                r_v2;
    pvp_pkg::t_meta      r_m2;
    logic signed [QB:0]  r_px, r_py;
    assign mx = (ovf_x || qx > pvp_pkg::PX_LIMIT) ? pvp_pkg::PX_LIMIT : qx;
    assign my = (ovf_y || qy > pvp_pkg::PX_LIMIT) ? pvp_pkg::PX_LIMIT : qy;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else if (en) r_v2 <= r_vd[NS-1];
        if (en) begin
            r_m2 <= r_md[NS-1];
            r_px <= r_md[NS-1].neg_x ? -$signed({1'b0, mx}) : $signed({1'b0, mx});
            r_py <= r_md[NS-1].neg_y ? -$signed({1'b0, my}) : $signed({1'b0, my});
        end
    end

    // Scale by the viewport width.
    localparam int PW = QB + 15;
    logic                r_v3;
    pvp_pkg::t_meta      r_m3;
    logic signed [PW-1:0] r_sx, r_sy;
    logic signed [13:0]  ws;
    assign ws = $signed({1'b0, r_width});
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else if (en) r_v3 <= r_v2;
        if (en) begin
            r_m3 <= r_m2;
            r_sx <= PW'(r_px * ws);
            r_sy <= PW'(r_py * ws);
        end
    end

    // Halve toward zero, offset and saturate.
    localparam int SW = PW + 2;
    logic signed [PW-1:0] hx, hy;
    logic signed [SW-1:0] sx, sy, offw, offh, top;
    logic signed [31:0]   satx, saty;
    assign hx   = (r_sx + $signed({{(PW-1){1'b0}}, r_sx[PW-1]})) >>> 1;
    assign hy   = (r_sy + $signed({{(PW-1){1'b0}}, r_sy[PW-1]})) >>> 1;
    assign offw = $signed(SW'(r_width)  << (FB - 1));
    assign offh = $signed(SW'(r_height) << (FB - 1));
    assign top  = $signed(SW'(r_height) << FB) - $signed(SW'(1) << FB);
    assign sx   = SW'(hx) + offw;
    assign sy   = top - (SW'(hy) + offh);
    assign satx = (sx > $signed(SW'(32'h7fff_ffff))) ? 32'sh7fff_ffff :
                  (sx < -$signed(SW'(33'h0_8000_0000))) ? 32'sh8000_0000 : sx[31:0];
    assign saty = (sy > $signed(SW'(32'h7fff_ffff))) ? 32'sh7fff_ffff :
                  (sy < -$signed(SW'(33'h0_8000_0000))) ? 32'sh8000_0000 : sy[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else if (en) o_valid <= r_v3;
        if (en) begin
            o_result.screen_x      <= r_m3.behind ? 32'sd0 : satx;
            o_result.screen_y      <= r_m3.behind ? 32'sd0 : saty;
            o_result.screen_z      <= r_m3.z;
            o_result.behind_camera <= r_m3.behind;
        end
    end
endmodule

/* rtl/core/pvp_checker.sv */
// Port-level checks for the projection block, bound to its top level.
// Uses the assertion macros header and pvp_pkg payload types.
`include "perspective_viewport_projection_defines.svh"

module pvp_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_valid,
    input logic             i_stall,
    input pvp_pkg::t_screen o_result
);
    `PVP_ASSERT(a_hold_stalled, o_valid && i_stall |=> o_valid && $stable(o_result))
    `PVP_ASSERT(a_behind_zero, o_valid && o_result.behind_camera |-> o_result.screen_x == 0 && o_result.screen_y == 0)
    `PVP_ASSERT(a_behind_flag, o_valid |-> o_result.behind_camera == (o_result.screen_z <= 0))
    `PVP_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !o_valid)
endmodule

bind perspective_viewport_projection pvp_checker u_pvp_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid),
    .i_stall(i_stall), .o_result(o_result)
);

/* bench/perspective_viewport_projection_tb.sv */
// Self-checking bench for the perspective divide and viewport transform block.
// Depends on pvp_pkg and perspective_viewport_projection; predicts every vertex in 64 bits.
module perspective_viewport_projection_tb;

    localparam int LATENCY = 47;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    pvp_pkg::t_vertex i_vertex;
    logic o_valid;
    logic i_stall;
    pvp_pkg::t_screen o_result;
    logic i_cfg_we;
    logic [pvp_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [31:0] i_cfg_data;

    logic [31:0] dist_h;
    logic [31:0] dist_v;
    logic [12:0] vp_width;
    logic [12:0] vp_height;

    pvp_pkg::t_screen screen_queue[$];
    int send_idle_pct;
    int recv_stall_pct;
    int error_count;

    perspective_viewport_projection i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_vertex(i_vertex),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_result(o_result),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("** perspective_viewport_projection: FAILED **");
        $finish;
    end

    function automatic longint sat_to_px(longint v);
        longint lim;
        lim = longint'(1) << 40;
        if (v > lim) begin
            return lim;
        end
        if (v < -lim) begin
            return -lim;
        end
        return v;
    endfunction

    function automatic logic [31:0] clamp_q16(longint v);
        if (v > 64'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic pvp_pkg::t_screen project_vertex(pvp_pkg::t_vertex v);
        pvp_pkg::t_screen r;
        longint x, y, z, w, h, one, px, py, sx, sy;
        x = longint'(v.cam_x);
        y = longint'(v.cam_y);
        z = longint'(v.cam_z);
        w = longint'({19'd0, vp_width});
        h = longint'({19'd0, vp_height});
        one = longint'(1) << pvp_pkg::FRAC_BITS;
        r.screen_z = v.cam_z;
        if (z <= 0) begin
            r.screen_x = '0;
            r.screen_y = '0;
            r.behind_camera = 1'b1;
            return r;
        end
        px = sat_to_px((longint'({32'd0, dist_h}) * x) / z);
        py = sat_to_px((longint'({32'd0, dist_v}) * y) / z);
        sx = (px * w) / 2 + (w * one) / 2;
        sy = (h - 1) * one - ((py * w) / 2 + (h * one) / 2);
        r.screen_x = clamp_q16(sx);
        r.screen_y = clamp_q16(sy);
        r.behind_camera = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch on %s: got %h, expected %h", field, got, want);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        pvp_pkg::t_screen want;
        if (i_rst_n) begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
            if (o_valid && !i_stall) begin
                if (screen_queue.size() == 0) begin
                    report_mismatch("unexpected transfer", o_result.screen_x, 32'd0);
                end else begin
                    want = screen_queue.pop_front();
                    if (o_result.screen_x !== want.screen_x)
                        report_mismatch("screen_x", o_result.screen_x, want.screen_x);
                    if (o_result.screen_y !== want.screen_y)
                        report_mismatch("screen_y", o_result.screen_y, want.screen_y);
                    if (o_result.screen_z !== want.screen_z)
                        report_mismatch("screen_z", o_result.screen_z, want.screen_z);
                    if (o_result.behind_camera !== want.behind_camera)
                        report_mismatch("behind_camera", {31'd0, o_result.behind_camera},
                                        {31'd0, want.behind_camera});
                end
            end
        end
    end

    task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_vertex <= '{cam_x: x, cam_y: y, cam_z: z};
        do begin
            @(posedge i_clk);
        end while (o_stall);
        screen_queue.push_back(project_vertex('{cam_x: x, cam_y: y, cam_z: z}));
    endtask

    task automatic drain;
        int guard;
        guard = 0;
        i_valid <= 1'b0;
        while (screen_queue.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic write_reg(pvp_pkg::t_cfg_idx idx, logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            pvp_pkg::CFG_VIEW_DIST_H: dist_h = data;
            pvp_pkg::CFG_VIEW_DIST_V: dist_v = data;
            pvp_pkg::CFG_VIEWPORT_WIDTH: vp_width = data[12:0];
            pvp_pkg::CFG_VIEWPORT_HEIGHT: vp_height = data[12:0];
            default: ;
        endcase
    endtask

    task automatic configure(logic [31:0] dh, logic [31:0] dv, logic [12:0] w, logic [12:0] h);
        drain();
        write_reg(pvp_pkg::CFG_VIEW_DIST_H, dh);
        write_reg(pvp_pkg::CFG_VIEW_DIST_V, dv);
        write_reg(pvp_pkg::CFG_VIEWPORT_WIDTH, {19'd0, w});
        write_reg(pvp_pkg::CFG_VIEWPORT_HEIGHT, {19'd0, h});
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] random_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(2000000)) - 1000000);
            2: return {{8{1'($urandom_range(1))}}, 24'($urandom)};
            default: return 32'($urandom_range(65536 * 20));
        endcase
    endfunction

    function automatic logic [31:0] random_depth();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'($urandom_range(4));
            2: return 32'($signed(0) - $signed($urandom_range(3)));
            default: return 32'($urandom_range(65536 * 50, 1024));
        endcase
    endfunction

    task automatic test_directed_extremes;
        send_vertex(32'h0, 32'h0, 32'h0001_0000);
        send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
        send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001);
        send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_vertex(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_vertex(32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000);
        send_vertex(32'hFFFF_FFFF, 32'h0000_0001, 32'h0001_0000);
        send_vertex(32'h1234_5678, 32'h8765_4321, 32'h0000_0000);
        send_vertex(32'h1234_5678, 32'h1234_5678, 32'h8000_0000);
        send_vertex(32'h0001_0000, 32'h0001_0000, 32'hFFFF_FFFF);
        send_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_vertex(32'h0000_8000, 32'hFFFF_8000, 32'h0000_3000);
    endtask

    task automatic test_random(int count);
        repeat (count) begin
            send_vertex(random_coord(), random_coord(), random_depth());
        end
    endtask

    task automatic test_register_extremes;
        configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 13'd4096, 13'd4096);
        test_directed_extremes();
        test_random(30);
        configure(32'h0, 32'h0, 13'd1, 13'd1);
        test_directed_extremes();
        test_random(30);
        configure(32'h0001_0000, 32'h0001_0000, 13'd0, 13'd0);
        test_random(20);
        configure(32'h0001_0000, 32'h0001_0000, 13'h1FFF, 13'h1FFF);
        test_random(20);
    endtask

    task automatic test_random_settings;
        repeat (6) begin
            configure($urandom, $urandom_range(65536 * 4), 13'($urandom_range(4096, 1)),
                      13'($urandom_range(4096, 1)));
            test_random(35);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_vertex = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        error_count = 0;
        dist_h = pvp_pkg::DIST_RESET;
        dist_v = pvp_pkg::DIST_RESET;
        vp_width = pvp_pkg::WIDTH_RESET;
        vp_height = pvp_pkg::HEIGHT_RESET;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_extremes();
        test_random(60);
        send_idle_pct = 54;
        test_register_extremes();
        send_idle_pct = 0;
        recv_stall_pct = 54;
        test_random_settings();
        send_idle_pct = 6;
        recv_stall_pct = 6;
        configure(pvp_pkg::DIST_RESET, pvp_pkg::DIST_RESET, pvp_pkg::WIDTH_RESET,
                  pvp_pkg::HEIGHT_RESET);
        test_random(60);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();

        if (error_count == 0 && screen_queue.size() == 0) begin
            $display("** perspective_viewport_projection: PASSED **");
        end else begin
            $display("** perspective_viewport_projection: FAILED **");
        end
        $finish;
    end
endmodule
